// ===== sv/bffs_pkg.sv =====
package bffs_pkg;

  localparam int KIND_W = 2;
  localparam int POS_W  = 11;
  localparam int LEN_W  = 12;
  localparam int DIV_W  = 13;

  localparam logic [LEN_W-1:0] LEN_RESET = 12'd2048;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIND  = 2'd0,
    KIND_TEST  = 2'd1,
    KIND_SET   = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

endpackage

// ===== sv/bitmap_first_free_search.sv =====
// Allocation bitmap with find-first-clear, test, set and clear requests.
// Out-of-range test/set/clear requests end in DECODE; in-range ones read the
// word, then test or modify it in RMW. Find scans ceil(len / WORD_BITS) words at most.
// One item at a time; the map RAM read port, one word per cycle, sets the find time.
// Reset: length register to 2048, then a zeroing sweep of every map word
// with busy high. Results are strobed for one cycle on done; no stall.
module bitmap_first_free_search #(
  parameter int WORD_BITS = 32,
  parameter int WORDS     = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bffs_pkg::LEN_W-1:0]  cfg_data_i,
  input  logic                        start,
  output logic                        busy,
  input  logic [bffs_pkg::KIND_W-1:0] kind_i,
  input  logic [bffs_pkg::POS_W-1:0]  bit_index_i,
  output logic                        done_o,
  output logic                        hit_o,
  output logic [bffs_pkg::POS_W-1:0]  position_o,
  output logic                        range_error_o
);

  localparam int BW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW    = $clog2(WORDS + 1);
  localparam int CAP   = WORDS * WORD_BITS;
  localparam int SH    = bffs_pkg::DIV_W + BW;
  localparam int RECIP = ((2 ** SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int PW    = bffs_pkg::DIV_W + SH;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_FIND,
    ST_RMW
  } state_e;

  state_e                       state_q;
  bffs_pkg::kind_e              kind_q;
  logic [bffs_pkg::POS_W-1:0]   idx_q;
  logic [bffs_pkg::LEN_W-1:0]   len_q;
  logic [bffs_pkg::LEN_W-1:0]   bits_q;
  logic [AW-1:0]                word_q;
  logic [CW-1:0]                count_q;
  logic                         done_q;
  logic                         hit_q;
  logic [bffs_pkg::POS_W-1:0]   pos_q;
  logic                         err_q;

  logic [bffs_pkg::LEN_W-1:0]   len_d;
  logic [bffs_pkg::DIV_W-1:0]   div_in;
  logic [PW-1:0]                prod;
  logic [bffs_pkg::DIV_W-1:0]   quot;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [WORD_BITS-1:0]         mem_wdata;
  logic [AW-1:0]                mem_raddr;
  logic [WORD_BITS-1:0]         mem_rdata;
  logic                         word_full;
  logic [BW-1:0]                zero_pos;
  logic [31:0]                  abs_pos;
  logic [31:0]                  bit_off;
  logic [BW-1:0]                bit_sel;
  logic [WORD_BITS-1:0]         bit_mask;

  bffs_map_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bffs_zero_find #(
    .WORD_BITS (WORD_BITS),
    .BW        (BW)
  ) u_zero (
    .word_i (mem_rdata),
    .full_o (word_full),
    .pos_o  (zero_pos)
  );

  // usable length saturates at capacity
  assign len_d = (32'(bits_q) > 32'(CAP)) ? bffs_pkg::LEN_W'(CAP) : bits_q;

  // divide by WORD_BITS through a reciprocal; find takes ceil(len / WORD_BITS)
  assign div_in = (kind_q == bffs_pkg::KIND_FIND)
                ? bffs_pkg::DIV_W'(32'(len_q) + 32'(WORD_BITS - 1))
                : bffs_pkg::DIV_W'(idx_q);
  assign prod   = PW'(div_in) * PW'(RECIP);
  assign quot   = prod[PW-1:SH];

  assign abs_pos  = 32'(word_q) * 32'(WORD_BITS) + 32'(zero_pos);
  assign bit_off  = 32'(idx_q) - 32'(word_q) * 32'(WORD_BITS);
  assign bit_sel  = BW'(bit_off);
  assign bit_mask = WORD_BITS'(1) << bit_sel;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = word_q;
    mem_wdata = '0;
    mem_raddr = word_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_DECODE: begin
        mem_raddr = (kind_q == bffs_pkg::KIND_FIND) ? '0 : AW'(quot);
      end
      ST_FIND: begin
        mem_raddr = AW'(32'(word_q) + 32'd1);
      end
      ST_RMW: begin
        if (kind_q == bffs_pkg::KIND_SET) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata | bit_mask;
        end else if (kind_q == bffs_pkg::KIND_CLEAR) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata & ~bit_mask;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= bffs_pkg::LEN_RESET;
    end else if (cfg_we_i) begin
      bits_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      word_q  <= '0;
      done_q  <= 1'b0;
      kind_q  <= bffs_pkg::KIND_FIND;
      idx_q   <= '0;
      len_q   <= '0;
      count_q <= '0;
      hit_q   <= 1'b0;
      pos_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          if (32'(word_q) == 32'(WORDS - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            word_q <= AW'(32'(word_q) + 32'd1);
          end
        end
        ST_IDLE: begin
          if (start) begin
            kind_q  <= bffs_pkg::kind_e'(kind_i);
            idx_q   <= bit_index_i;
            len_q   <= len_d;
            state_q <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          hit_q <= 1'b0;
          err_q <= 1'b0;
          if (kind_q == bffs_pkg::KIND_FIND) begin
            pos_q <= '0;
            if (quot == '0) begin
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              count_q <= CW'(quot);
              word_q  <= '0;
              state_q <= ST_FIND;
            end
          end else begin
            pos_q <= idx_q;
            if (32'(idx_q) >= 32'(len_q)) begin
              err_q   <= 1'b1;
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              word_q  <= AW'(quot);
              state_q <= ST_RMW;
            end
          end
        end
        ST_FIND: begin
          if (!word_full) begin
            if (abs_pos < 32'(len_q)) begin
              hit_q <= 1'b1;
              pos_q <= bffs_pkg::POS_W'(abs_pos);
            end
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else if (32'(word_q) + 32'd1 >= 32'(count_q)) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            word_q <= AW'(32'(word_q) + 32'd1);
          end
        end
        ST_RMW: begin
          if (kind_q == bffs_pkg::KIND_TEST) begin
            hit_q <= mem_rdata[bit_sel];
          end
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign position_o    = pos_q;
  assign range_error_o = err_q;

endmodule

// ===== sv/bffs_map_ram.sv =====
module bffs_map_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bffs_zero_find.sv =====
module bffs_zero_find #(
  parameter int WORD_BITS = 32,
  parameter int BW        = 5
) (
  input  logic [WORD_BITS-1:0] word_i,
  output logic                 full_o,
  output logic [BW-1:0]        pos_o
);

  always_comb begin
    pos_o = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!word_i[b]) begin
        pos_o = BW'(b);
      end
    end
  end

  assign full_o = &word_i;

endmodule
